// ===== rtl/pqlut_pkg.sv =====
// ----------------------------------------------------------------------------
// pqlut_pkg
// Shared widths, codes and control types of the PQ table distance scorer.
// ----------------------------------------------------------------------------
package pqlut_pkg;

   localparam int MAX_SUBSPACES_DEF = 64;
   localparam int CODEBOOK_SIZE_DEF = 256;

   localparam int OPERATION_W       = 1;
   localparam int TABLE_SUBSPACE_W  = 6;
   localparam int TABLE_CODEWORD_W  = 8;
   localparam int DOT_VALUE_W       = 32;
   localparam int NORM_VALUE_W      = 31;
   localparam int CODE_BYTE_W       = 8;
   localparam int SLOT_W            = 5;
   localparam int DISTANCE_W        = 42;

   localparam int SUBSPACE_COUNT_W  = 7;
   localparam int QUERY_NORM_W      = 40;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 40;

   localparam int NIBBLE_W          = 4;
   localparam int CODE_CMP_W        = 9;
   localparam int OUT_FIFO_DEPTH    = 8;

   localparam logic [CODE_BYTE_W-1:0]      NIBBLE_MASK           = 8'h0F;
   localparam logic [SLOT_W-1:0]           NIBBLE_SLOT_SPLIT     = 5'd16;
   localparam logic [SUBSPACE_COUNT_W-1:0] SUBSPACE_COUNT_RESET  = 7'd8;

   typedef enum logic [OPERATION_W-1:0] {
      OP_TABLE_WRITE = 1'b0,
      OP_SCORE       = 1'b1
   } operation_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_METRIC_MODE     = 2'd0,
      CSR_CODE_WIDTH_MODE = 2'd1,
      CSR_SUBSPACE_COUNT  = 2'd2,
      CSR_QUERY_NORM_SQ   = 2'd3
   } csr_index_type;

   typedef enum logic {
      METRIC_L2            = 1'b0,
      METRIC_INNER_PRODUCT = 1'b1
   } metric_type;

   typedef enum logic {
      CODE_NIBBLE = 1'b0,
      CODE_BYTE   = 1'b1
   } code_width_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic code_ok;
   } accum_ctl_type;

   typedef struct packed {
      logic fin_pending;
      logic dist_pending;
   } accum_status_type;

endpackage

// ===== rtl/pqlut_req_if.sv =====
// ----------------------------------------------------------------------------
// pqlut_req_if
// Request channel: table writes and score code bytes.
// ----------------------------------------------------------------------------
interface pqlut_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [pqlut_pkg::OPERATION_W-1:0]      operation;
   logic [pqlut_pkg::TABLE_SUBSPACE_W-1:0] table_subspace;
   logic [pqlut_pkg::TABLE_CODEWORD_W-1:0] table_codeword;
   logic signed [pqlut_pkg::DOT_VALUE_W-1:0] dot_value;
   logic [pqlut_pkg::NORM_VALUE_W-1:0]     norm_value;
   logic [pqlut_pkg::CODE_BYTE_W-1:0]      code_byte;
   logic [pqlut_pkg::SLOT_W-1:0]           slot;

   modport source (
      output valid, operation, table_subspace, table_codeword,
             dot_value, norm_value, code_byte, slot,
      input  ready
   );

   modport sink (
      input  valid, operation, table_subspace, table_codeword,
             dot_value, norm_value, code_byte, slot,
      output ready
   );
endinterface

// ===== rtl/pqlut_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pqlut_rsp_if
// Result channel: one distance per scored vector.
// ----------------------------------------------------------------------------
interface pqlut_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [pqlut_pkg::DISTANCE_W-1:0] distance;

   modport source (
      output valid, distance,
      input  ready
   );

   modport sink (
      input  valid, distance,
      output ready
   );
endinterface

// ===== rtl/pqlut_ram.sv =====
// ----------------------------------------------------------------------------
// pqlut_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module pqlut_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [DATA_W-1:0]        write_data,
   output logic [DATA_W-1:0]        read_data
);

   logic [DATA_W-1:0] ram_ff [DEPTH];
   logic [DATA_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         ram_ff[address] <= write_data;
      end
      read_data_ff <= ram_ff[address];
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/pqlut_out_fifo.sv =====
// ----------------------------------------------------------------------------
// pqlut_out_fifo
// Result queue between the distance stage and the response channel.
// ----------------------------------------------------------------------------
module pqlut_out_fifo #(
   parameter int DEPTH  = 8,
   parameter int DATA_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DATA_W-1:0]          push_data,
   input  logic                       pop_ready,
   output logic                       pop_valid,
   output logic [DATA_W-1:0]          pop_data,
   output logic [$clog2(DEPTH):0]     count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid & pop_ready;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/pqlut_accum.sv =====
// ----------------------------------------------------------------------------
// pqlut_accum
// Dot and norm accumulators fed by table read data, then the distance stage.
// ----------------------------------------------------------------------------
module pqlut_accum #(
   parameter int MAX_SUBSPACES = pqlut_pkg::MAX_SUBSPACES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pqlut_pkg::accum_ctl_type              ctl,
   input  logic [pqlut_pkg::DOT_VALUE_W+pqlut_pkg::NORM_VALUE_W-1:0] table_data,
   input  logic                                  metric_mode,
   input  logic [pqlut_pkg::QUERY_NORM_W-1:0]    query_norm_sq,
   output pqlut_pkg::accum_status_type           status,
   output logic                                  dist_valid,
   output logic [pqlut_pkg::DISTANCE_W-1:0]      distance
);

   localparam int SUB_W      = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1;
   localparam int DOT_W      = pqlut_pkg::DOT_VALUE_W;
   localparam int NORM_W     = pqlut_pkg::NORM_VALUE_W;
   localparam int DOT_SUM_W  = DOT_W + SUB_W;
   localparam int NORM_SUM_W = NORM_W + SUB_W;
   localparam int DIST_W     = pqlut_pkg::DISTANCE_W;

   logic [DOT_W-1:0]      entry_dot;
   logic [NORM_W-1:0]     entry_norm;
   logic [DOT_SUM_W-1:0]  dot_add;
   logic [NORM_SUM_W-1:0] norm_add;
   logic [DOT_SUM_W-1:0]  dot_next;
   logic [NORM_SUM_W-1:0] norm_next;

   logic [DOT_SUM_W-1:0]  dot_sum_ff, dot_sum_in;
   logic [NORM_SUM_W-1:0] norm_sum_ff, norm_sum_in;
   logic [DOT_SUM_W-1:0]  fin_dot_ff;
   logic [NORM_SUM_W-1:0] fin_norm_ff;
   logic                  fin_valid_ff;

   logic [DIST_W-1:0]     dot_ext;
   logic [DIST_W-1:0]     dist_in;
   logic [DIST_W-1:0]     dist_ff;
   logic                  dist_valid_ff;

   assign entry_dot  = table_data[DOT_W+NORM_W-1:NORM_W];
   assign entry_norm = table_data[NORM_W-1:0];

   always_comb begin
      dot_add  = '0;
      norm_add = '0;
      if (ctl.code_ok) begin
         dot_add  = {{(DOT_SUM_W-DOT_W){entry_dot[DOT_W-1]}}, entry_dot};
         norm_add = NORM_SUM_W'(entry_norm);
      end
      dot_next    = dot_sum_ff + dot_add;
      norm_next   = norm_sum_ff + norm_add;
      dot_sum_in  = dot_sum_ff;
      norm_sum_in = norm_sum_ff;
      if (ctl.valid) begin
         dot_sum_in  = ctl.last ? '0 : dot_next;
         norm_sum_in = ctl.last ? '0 : norm_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_sum_ff    <= '0;
         norm_sum_ff   <= '0;
         fin_valid_ff  <= 1'b0;
         dist_valid_ff <= 1'b0;
      end else begin
         dot_sum_ff    <= dot_sum_in;
         norm_sum_ff   <= norm_sum_in;
         fin_valid_ff  <= ctl.valid & ctl.last;
         dist_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.valid && ctl.last) begin
         fin_dot_ff  <= dot_next;
         fin_norm_ff <= norm_next;
      end
   end

   // distance = qn - 2*dot + norm, or -dot, both modulo the output width
   always_comb begin
      dot_ext = {{(DIST_W-DOT_SUM_W){fin_dot_ff[DOT_SUM_W-1]}}, fin_dot_ff};
      if (metric_mode == pqlut_pkg::METRIC_INNER_PRODUCT) begin
         dist_in = -dot_ext;
      end else begin
         dist_in = DIST_W'(query_norm_sq) - {dot_ext[DIST_W-2:0], 1'b0}
                   + DIST_W'(fin_norm_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid_ff) begin
         dist_ff <= dist_in;
      end
   end

   assign status.fin_pending  = fin_valid_ff;
   assign status.dist_pending = dist_valid_ff;
   assign dist_valid          = dist_valid_ff;
   assign distance            = dist_ff;

endmodule

// ===== rtl/pq_lut_distance_scorer_core.sv =====
// ----------------------------------------------------------------------------
// pq_lut_distance_scorer_core
// Product-quantization distance scorer: table load and per-subspace lookup.
// ----------------------------------------------------------------------------
// Result path: s1 control, fin and dist registers, then the result queue.
// Throughput: one request per cycle while the result queue has room, set by
//   the single table RAM port (one write or one lookup per cycle).
// Reset: clears counters, sums, pipeline valids, result queue and config
//   registers; table contents stay undefined until written.
// ----------------------------------------------------------------------------
module pq_lut_distance_scorer_core #(
   parameter int MAX_SUBSPACES = pqlut_pkg::MAX_SUBSPACES_DEF,
   parameter int CODEBOOK_SIZE = pqlut_pkg::CODEBOOK_SIZE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   pqlut_req_if.sink                          req_chan,
   pqlut_rsp_if.source                        rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [pqlut_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pqlut_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int SUB_W    = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1;
   localparam int CMP_W    = ((SUB_W > pqlut_pkg::SUBSPACE_COUNT_W) ?
                              SUB_W : pqlut_pkg::SUBSPACE_COUNT_W) + 1;
   localparam int DEPTH    = MAX_SUBSPACES * CODEBOOK_SIZE;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int ENTRY_W  = pqlut_pkg::DOT_VALUE_W + pqlut_pkg::NORM_VALUE_W;
   localparam int FCNT_W   = $clog2(pqlut_pkg::OUT_FIFO_DEPTH) + 1;
   localparam int OCC_W    = FCNT_W + 1;
   localparam int CCMP_W   = pqlut_pkg::CODE_CMP_W;
   localparam int BYTE_W   = pqlut_pkg::CODE_BYTE_W;

   // configuration registers
   logic                                       metric_mode_ff;
   logic                                       code_width_mode_ff;
   logic [pqlut_pkg::SUBSPACE_COUNT_W-1:0]     subspace_count_ff;
   logic [pqlut_pkg::QUERY_NORM_W-1:0]         query_norm_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_mode_ff     <= pqlut_pkg::METRIC_L2;
         code_width_mode_ff <= pqlut_pkg::CODE_NIBBLE;
         subspace_count_ff  <= pqlut_pkg::SUBSPACE_COUNT_RESET;
         query_norm_sq_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            pqlut_pkg::CSR_METRIC_MODE: begin
               metric_mode_ff <= csr_write_data[0];
            end
            pqlut_pkg::CSR_CODE_WIDTH_MODE: begin
               code_width_mode_ff <= csr_write_data[0];
            end
            pqlut_pkg::CSR_SUBSPACE_COUNT: begin
               subspace_count_ff <= csr_write_data[pqlut_pkg::SUBSPACE_COUNT_W-1:0];
            end
            pqlut_pkg::CSR_QUERY_NORM_SQ: begin
               query_norm_sq_ff <= csr_write_data[pqlut_pkg::QUERY_NORM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // request stage
   logic                    req_accept;
   logic                    is_score;
   logic [BYTE_W-1:0]       code;
   logic                    code_ok;
   logic [CMP_W-1:0]        active_count;
   logic [CMP_W-1:0]        last_index;
   logic                    sub_last;
   logic                    write_ok;
   logic                    table_we;
   logic [ADDR_W-1:0]       table_addr;
   logic [SUB_W-1:0]        counter_ff, counter_in;
   logic [ENTRY_W-1:0]      table_rdata;

   pqlut_pkg::accum_ctl_type    s1_ctl_ff, s1_ctl_in;
   pqlut_pkg::accum_status_type acc_status;

   logic                                   dist_valid;
   logic [pqlut_pkg::DISTANCE_W-1:0]       dist_data;
   logic [pqlut_pkg::DISTANCE_W-1:0]       fifo_data;
   logic [FCNT_W-1:0]                      fifo_count;
   logic [OCC_W-1:0]                       occupancy;

   assign req_accept = req_chan.valid & req_chan.ready;
   assign is_score   = (req_chan.operation == pqlut_pkg::OP_SCORE);

   always_comb begin
      if (code_width_mode_ff == pqlut_pkg::CODE_BYTE) begin
         code = req_chan.code_byte;
      end else if (req_chan.slot >= pqlut_pkg::NIBBLE_SLOT_SPLIT) begin
         code = req_chan.code_byte >> pqlut_pkg::NIBBLE_W;
      end else begin
         code = req_chan.code_byte & pqlut_pkg::NIBBLE_MASK;
      end
   end

   assign code_ok = (CCMP_W'(code) < CCMP_W'(CODEBOOK_SIZE));

   always_comb begin
      active_count = CMP_W'(subspace_count_ff);
      if (subspace_count_ff == '0) begin
         active_count = CMP_W'(1);
      end else if (active_count > CMP_W'(MAX_SUBSPACES)) begin
         active_count = CMP_W'(MAX_SUBSPACES);
      end
      last_index = active_count - 1'b1;
   end

   assign sub_last = (CMP_W'(counter_ff) >= last_index);

   assign write_ok = (CMP_W'(req_chan.table_subspace) < CMP_W'(MAX_SUBSPACES))
                   && (CCMP_W'(req_chan.table_codeword) < CCMP_W'(CODEBOOK_SIZE));
   assign table_we = req_accept & ~is_score & write_ok;

   always_comb begin
      if (is_score) begin
         table_addr = ADDR_W'(counter_ff) * ADDR_W'(CODEBOOK_SIZE) + ADDR_W'(code);
      end else begin
         table_addr = ADDR_W'(req_chan.table_subspace) * ADDR_W'(CODEBOOK_SIZE)
                    + ADDR_W'(req_chan.table_codeword);
      end
   end

   always_comb begin
      counter_in = counter_ff;
      if (req_accept && is_score) begin
         counter_in = sub_last ? '0 : counter_ff + 1'b1;
      end
      s1_ctl_in.valid   = req_accept & is_score;
      s1_ctl_in.last    = sub_last;
      s1_ctl_in.code_ok = code_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         s1_ctl_ff  <= '0;
      end else begin
         counter_ff <= counter_in;
         s1_ctl_ff  <= s1_ctl_in;
      end
   end

   pqlut_ram #(
      .DATA_W (ENTRY_W),
      .DEPTH  (DEPTH)
   ) u_table (
      .clock        (clock),
      .write_enable (table_we),
      .address      (table_addr),
      .write_data   ({req_chan.dot_value, req_chan.norm_value}),
      .read_data    (table_rdata)
   );

   pqlut_accum #(
      .MAX_SUBSPACES (MAX_SUBSPACES)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .ctl           (s1_ctl_ff),
      .table_data    (table_rdata),
      .metric_mode   (metric_mode_ff),
      .query_norm_sq (query_norm_sq_ff),
      .status        (acc_status),
      .dist_valid    (dist_valid),
      .distance      (dist_data)
   );

   pqlut_out_fifo #(
      .DEPTH  (pqlut_pkg::OUT_FIFO_DEPTH),
      .DATA_W (pqlut_pkg::DISTANCE_W)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (dist_valid),
      .push_data (dist_data),
      .pop_ready (rsp_chan.ready),
      .pop_valid (rsp_chan.valid),
      .pop_data  (fifo_data),
      .count     (fifo_count)
   );

   assign rsp_chan.distance = $signed(fifo_data);

   // results in flight plus queued; a new request may add one
   assign occupancy = OCC_W'(fifo_count)
                    + OCC_W'(s1_ctl_ff.valid & s1_ctl_ff.last)
                    + OCC_W'(acc_status.fin_pending)
                    + OCC_W'(acc_status.dist_pending);

   assign req_chan.ready = (occupancy < OCC_W'(pqlut_pkg::OUT_FIFO_DEPTH));

   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      dist_valid |-> ((fifo_count < FCNT_W'(pqlut_pkg::OUT_FIFO_DEPTH)) || rsp_chan.ready))
      else $error("result queue overflow");

   a_counter_wraps: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_score && sub_last) |=> (counter_ff == '0))
      else $error("subspace counter did not restart after last subspace");

   a_write_no_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_score) |=> !s1_ctl_ff.valid)
      else $error("table write entered the accumulate stage");

endmodule

// ===== tb/sv/pq_lut_distance_compare.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pq_lut_distance_compare
// Watches the request, result and register ports of the PQ distance scorer.
// Keeps its own copy of the lookup tables, sums and registers, predicts each
// distance, and checks the results in order.
// ----------------------------------------------------------------------------
module pq_lut_distance_compare
   import pqlut_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   pqlut_req_if                   req_mon,
   pqlut_rsp_if                   rsp_mon,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     pending_results,
   output int                     fail_count,
   output int                     distance_count
);

   localparam int TABLE_DEPTH = MAX_SUBSPACES_DEF * CODEBOOK_SIZE_DEF;

   logic signed [DOT_VALUE_W-1:0]  dot_lut [TABLE_DEPTH];
   logic [NORM_VALUE_W-1:0]        norm_lut [TABLE_DEPTH];
   longint                         dot_sum = 0;
   longint                         norm_sum = 0;
   int                             sub_pos = 0;
   metric_type                     metric = METRIC_L2;
   code_width_type                 code_width = CODE_NIBBLE;
   logic [SUBSPACE_COUNT_W-1:0]    subspace_count = SUBSPACE_COUNT_RESET;
   logic [QUERY_NORM_W-1:0]        query_norm = '0;
   logic signed [DISTANCE_W-1:0]   expected_distances [$];
   int                             failures = 0;
   int                             checked = 0;

   always @(posedge clock) begin : track
      int                           code;
      int                           idx;
      int                           last;
      longint                       dist_val;
      logic signed [DISTANCE_W-1:0] want;
      if (reset) begin
         dot_sum = 0;
         norm_sum = 0;
         sub_pos = 0;
         metric = METRIC_L2;
         code_width = CODE_NIBBLE;
         subspace_count = SUBSPACE_COUNT_RESET;
         query_norm = '0;
         expected_distances.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_distances.size() == 0) begin
               $error("distance with no score pending: actual %0d", rsp_mon.distance);
               failures++;
            end else begin
               want = expected_distances.pop_front();
               checked++;
               if (rsp_mon.distance !== want) begin
                  $error("distance mismatch: expected %0d, actual %0d",
                         want, rsp_mon.distance);
                  failures++;
               end
            end
         end

         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.operation == OP_TABLE_WRITE) begin
               idx = int'(req_mon.table_subspace) * CODEBOOK_SIZE_DEF
                     + int'(req_mon.table_codeword);
               dot_lut[idx] = req_mon.dot_value;
               norm_lut[idx] = req_mon.norm_value;
            end else begin
               if (code_width == CODE_BYTE) begin
                  code = int'(req_mon.code_byte);
               end else if (req_mon.slot >= NIBBLE_SLOT_SPLIT) begin
                  code = int'(req_mon.code_byte >> NIBBLE_W);
               end else begin
                  code = int'(req_mon.code_byte & NIBBLE_MASK);
               end
               idx = sub_pos * CODEBOOK_SIZE_DEF + code;
               dot_sum += longint'(dot_lut[idx]);
               norm_sum += longint'(norm_lut[idx]);

               // zero acts as one subspace, large counts saturate
               if (subspace_count == '0) begin
                  last = 0;
               end else if (int'(subspace_count) > MAX_SUBSPACES_DEF) begin
                  last = MAX_SUBSPACES_DEF - 1;
               end else begin
                  last = int'(subspace_count) - 1;
               end

               if (sub_pos >= last) begin
                  if (metric == METRIC_INNER_PRODUCT) begin
                     dist_val = -dot_sum;
                  end else begin
                     dist_val = longint'(query_norm) - 2 * dot_sum + norm_sum;
                  end
                  want = DISTANCE_W'(dist_val);
                  expected_distances.insert(expected_distances.size(), want);
                  dot_sum = 0;
                  norm_sum = 0;
                  sub_pos = 0;
               end else begin
                  sub_pos++;
               end
            end
         end

         if (csr_write_enable === 1'b1) begin
            case (csr_index)
               CSR_METRIC_MODE:     metric = metric_type'(csr_write_data[0]);
               CSR_CODE_WIDTH_MODE: code_width = code_width_type'(csr_write_data[0]);
               CSR_SUBSPACE_COUNT:  subspace_count = csr_write_data[SUBSPACE_COUNT_W-1:0];
               CSR_QUERY_NORM_SQ:   query_norm = csr_write_data[QUERY_NORM_W-1:0];
               default: begin
               end
            endcase
         end
      end
      pending_results <= expected_distances.size();
      fail_count <= failures;
      distance_count <= checked;
   end

endmodule

// ===== tb/sv/pq_lut_distance_scorer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pq_lut_distance_scorer_core_test
// Drives table loads, code bytes and register settings into the PQ distance
// scorer: a directed pass over the value extremes and corner cases, then
// random phases across metrics, code widths and subspace counts, six with idle
// gaps on both channels. Distances are checked by pq_lut_distance_compare.
// ----------------------------------------------------------------------------
module pq_lut_distance_scorer_core_test;
   import pqlut_pkg::*;

   localparam int SUBSPACES       = MAX_SUBSPACES_DEF;
   localparam int CODEWORDS       = CODEBOOK_SIZE_DEF;
   localparam int SETTLE_CYCLES   = 12;
   localparam int RANDOM_PHASES   = 9;
   localparam int ITEMS_PER_PHASE = 64;

   localparam logic signed [DOT_VALUE_W-1:0] DOT_MIN  = 32'sh8000_0000;
   localparam logic signed [DOT_VALUE_W-1:0] DOT_MAX  = 32'sh7FFF_FFFF;
   localparam logic [NORM_VALUE_W-1:0]       NORM_MAX = '1;
   localparam logic [QUERY_NORM_W-1:0]       QNORM_MAX = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             pending_results;
   int             fail_count;
   int             distance_count;
   int             request_count = 0;
   int             table_write_count = 0;
   int             score_pos = 0;
   int             last_score_sub = 7;
   code_width_type cur_width = CODE_NIBBLE;

   bit [CODEWORDS-1:0] written_map [SUBSPACES];
   logic [7:0]         cw_pool [SUBSPACES][CODEWORDS];
   int                 pool_size [SUBSPACES];

   pqlut_req_if req_chan ();
   pqlut_rsp_if rsp_chan ();

   pq_lut_distance_scorer_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   pq_lut_distance_compare distance_compare (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pending_results  (pending_results),
      .fail_count       (fail_count),
      .distance_count   (distance_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   function automatic logic signed [DOT_VALUE_W-1:0] random_dot();
      case ($urandom_range(0, 7))
         0:       return DOT_MIN;
         1:       return DOT_MAX;
         default: return DOT_VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [NORM_VALUE_W-1:0] random_norm();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return NORM_MAX;
         default: return NORM_VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [QUERY_NORM_W-1:0] random_query_norm();
      return {8'($urandom), $urandom};
   endfunction

   task automatic send_request(operation_type op,
                               logic [TABLE_SUBSPACE_W-1:0] sub,
                               logic [TABLE_CODEWORD_W-1:0] cw,
                               logic signed [DOT_VALUE_W-1:0] dot,
                               logic [NORM_VALUE_W-1:0] norm,
                               logic [CODE_BYTE_W-1:0] code_val,
                               logic [SLOT_W-1:0] slot_val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.operation      <= op;
      req_chan.table_subspace <= sub;
      req_chan.table_codeword <= cw;
      req_chan.dot_value      <= dot;
      req_chan.norm_value     <= norm;
      req_chan.code_byte      <= code_val;
      req_chan.slot           <= slot_val;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      request_count++;
   endtask

   task automatic load_entry(logic [TABLE_SUBSPACE_W-1:0] sub,
                             logic [TABLE_CODEWORD_W-1:0] cw,
                             logic signed [DOT_VALUE_W-1:0] dot,
                             logic [NORM_VALUE_W-1:0] norm);
      send_request(OP_TABLE_WRITE, sub, cw, dot, norm, CODE_BYTE_W'($urandom),
                   SLOT_W'($urandom));
      if (!written_map[sub][cw]) begin
         written_map[sub][cw] = 1'b1;
         cw_pool[sub][pool_size[sub]] = cw;
         pool_size[sub]++;
      end
      table_write_count++;
   endtask

   task automatic score_code(logic [CODE_BYTE_W-1:0] code_val,
                             logic [SLOT_W-1:0] slot_val);
      send_request(OP_SCORE, TABLE_SUBSPACE_W'($urandom), TABLE_CODEWORD_W'($urandom),
                   DOT_VALUE_W'($urandom), NORM_VALUE_W'($urandom), code_val, slot_val);
      if (score_pos >= last_score_sub) begin
         score_pos = 0;
      end else begin
         score_pos++;
      end
   endtask

   // code for the current subspace, loading its entry first if never written
   task automatic random_score();
      logic [7:0]             code;
      logic [CODE_BYTE_W-1:0] code_val;
      logic [SLOT_W-1:0]      slot_val;
      if (cur_width == CODE_BYTE && pool_size[score_pos] > 0
          && $urandom_range(0, 3) != 0) begin
         code = cw_pool[score_pos][$urandom_range(0, pool_size[score_pos] - 1)];
      end else if (cur_width == CODE_BYTE) begin
         code = 8'($urandom);
      end else begin
         code = 8'($urandom_range(0, 15));
      end
      if (!written_map[score_pos][code]) begin
         load_entry(TABLE_SUBSPACE_W'(score_pos), code, random_dot(), random_norm());
      end
      slot_val = SLOT_W'($urandom);
      if (cur_width == CODE_BYTE) begin
         code_val = code;
      end else if (slot_val >= NIBBLE_SLOT_SPLIT) begin
         code_val = {code[3:0], 4'($urandom)};
      end else begin
         code_val = {4'($urandom), code[3:0]};
      end
      score_code(code_val, slot_val);
   endtask

   task automatic program_regs(metric_type m, code_width_type w,
                               logic [SUBSPACE_COUNT_W-1:0] n,
                               logic [QUERY_NORM_W-1:0] q);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_METRIC_MODE;
      csr_write_data   <= CSR_DATA_W'(m);
      @(posedge clock);
      csr_index        <= CSR_CODE_WIDTH_MODE;
      csr_write_data   <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index        <= CSR_SUBSPACE_COUNT;
      csr_write_data   <= CSR_DATA_W'(n);
      @(posedge clock);
      csr_index        <= CSR_QUERY_NORM_SQ;
      csr_write_data   <= CSR_DATA_W'(q);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_width = w;
      if (n == '0) begin
         last_score_sub = 0;
      end else if (int'(n) > SUBSPACES) begin
         last_score_sub = SUBSPACES - 1;
      end else begin
         last_score_sub = int'(n) - 1;
      end
   endtask

   // let every expected distance come out and the pipeline empty
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      csr_write_enable        = 1'b0;
      csr_index               = CSR_METRIC_MODE;
      csr_write_data          = '0;
      req_chan.valid          = 1'b0;
      req_chan.operation      = OP_TABLE_WRITE;
      req_chan.table_subspace = '0;
      req_chan.table_codeword = '0;
      req_chan.dot_value      = '0;
      req_chan.norm_value     = '0;
      req_chan.code_byte      = '0;
      req_chan.slot           = '0;
      rsp_chan.ready          = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes of L2, nibble select, write during a score
      program_regs(METRIC_L2, CODE_NIBBLE, 7'd2, QNORM_MAX);
      load_entry(6'd0, 8'd0, DOT_MIN, NORM_MAX);
      load_entry(6'd1, 8'd15, DOT_MIN, NORM_MAX);
      load_entry(6'd0, 8'd1, DOT_MAX, 31'd0);
      load_entry(6'd1, 8'd1, DOT_MAX, 31'd0);
      score_code(8'hF0, 5'd0);
      score_code(8'hF3, 5'd31);
      score_code(8'h01, 5'd15);
      load_entry(6'd1, 8'd2, -32'sd1, 31'd1);
      score_code(8'h10, 5'd16);
      drain();

      program_regs(METRIC_INNER_PRODUCT, CODE_NIBBLE, 7'd2, '0);
      score_code(8'hE1, 5'd0);
      score_code(8'h1E, 5'd16);
      drain();

      // zero subspace count acts as one
      program_regs(METRIC_L2, CODE_BYTE, 7'd0, '0);
      load_entry(6'd0, 8'd255, 32'sd12345, 31'd678);
      score_code(8'hFF, 5'd31);
      load_entry(6'd0, 8'd128, DOT_MIN, NORM_MAX);
      score_code(8'h80, 5'd7);
      drain();

      // count lowered while a score is part way through
      program_regs(METRIC_L2, CODE_BYTE, 7'd4, random_query_norm());
      load_entry(6'd2, 8'd200, DOT_MAX, NORM_MAX);
      load_entry(6'd3, 8'd7, -32'sd3, 31'd5);
      score_code(8'h00, 5'd3);
      score_code(8'h0F, 5'd9);
      score_code(8'hC8, 5'd20);
      drain();
      program_regs(METRIC_L2, CODE_BYTE, 7'd2, random_query_norm());
      score_code(8'h07, 5'd0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         case (p / 3)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 85;
            end
            1: begin
               send_idle_pct = 85;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (p)
            0: program_regs(METRIC_L2, CODE_NIBBLE, 7'd8, QNORM_MAX);
            1: program_regs(METRIC_INNER_PRODUCT, CODE_BYTE, 7'd64, '0);
            2: program_regs(METRIC_INNER_PRODUCT, CODE_NIBBLE, 7'd0, random_query_norm());
            3: program_regs(METRIC_L2, CODE_BYTE, 7'd127, QNORM_MAX);
            4: program_regs(METRIC_L2, CODE_BYTE, 7'd1, '0);
            5: program_regs(METRIC_L2, CODE_NIBBLE, 7'd64, random_query_norm());
            default: program_regs(metric_type'($urandom_range(0, 1)),
                                  code_width_type'($urandom_range(0, 1)),
                                  SUBSPACE_COUNT_W'($urandom_range(0, 127)),
                                  random_query_norm());
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(0, 99) < 10) begin
               load_entry(TABLE_SUBSPACE_W'($urandom), TABLE_CODEWORD_W'($urandom),
                          random_dot(), random_norm());
            end else begin
               random_score();
            end
         end
      end

      drain();
      $display("covered %0d requests (%0d table writes), %0d distances checked",
               request_count, table_write_count, distance_count);
      $display("both metrics, nibble and byte codes, subspace counts 0 to 127");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
